/* rtl/core/mccr_pkg.sv */
// mccr_pkg: shared types, controller codes and helper functions for the cc remapper
// used by every module under rtl/core; depends on nothing
`default_nettype none

package mccr_pkg;

  localparam int SYNTH_CHANNELS = 2;
  localparam int QUEUE_DEPTH    = 2;

  // emitted nrpn framing controllers
  localparam logic [6:0] CC_NRPN_MSB   = 7'd99;
  localparam logic [6:0] CC_NRPN_LSB   = 7'd98;
  localparam logic [6:0] CC_DATA_ENTRY = 7'd6;
  localparam logic [6:0] CC_RPN_MSB    = 7'd101;
  localparam logic [6:0] CC_RPN_LSB    = 7'd100;
  localparam logic [6:0] CC_NULL_VALUE = 7'd127;

  // incoming controllers with special handling
  localparam logic [6:0] IN_OSC1_SHAPE = 7'd36;
  localparam logic [6:0] IN_OSC1_WAVE  = 7'd50;
  localparam logic [6:0] IN_OSC2_SHAPE = 7'd37;
  localparam logic [6:0] IN_OSC2_WAVE  = 7'd51;
  localparam logic [6:0] IN_SW_A       = 7'd80;
  localparam logic [6:0] IN_SW_B       = 7'd81;
  localparam logic [6:0] IN_SW_INV     = 7'd84;
  localparam logic [6:0] IN_NRPN_1     = 7'd20;
  localparam logic [6:0] IN_NRPN_2     = 7'd21;
  localparam logic [6:0] IN_NRPN_3     = 7'd22;
  localparam logic [6:0] IN_NRPN_4     = 7'd23;
  localparam logic [6:0] IN_LFO_TARGET = 7'd56;
  localparam logic [6:0] IN_LFO_RATE   = 7'd24;
  localparam logic [6:0] IN_LFO_SCALED = 7'd58;
  localparam logic [6:0] IN_LFO_DEPTH  = 7'd26;

  // wave and lfo mode state codes
  localparam logic [1:0] WAVE_SAW   = 2'd0;
  localparam logic [1:0] WAVE_TRI   = 2'd1;
  localparam logic [1:0] WAVE_PULSE = 2'd2;
  localparam logic [1:0] LFO_PITCH  = 2'd0;
  localparam logic [1:0] LFO_SHAPE  = 2'd1;
  localparam logic [1:0] LFO_CUTOFF = 2'd2;

  typedef struct packed {
    logic [3:0]      channel;
    logic            nrpn;
    logic            four;
    logic            msb;
    logic [6:0]      cc;
    logic [3:0][6:0] lsb;
    logic [3:0][6:0] nval;
  } desc_t;

  // three-way split of a 7-bit value at 43 and 86
  function automatic logic [1:0] level3(input logic [6:0] v);
    logic [1:0] r;
    if (v < 7'd43) begin
      r = 2'd0;
    end else if (v < 7'd86) begin
      r = 2'd1;
    end else begin
      r = 2'd2;
    end
    return r;
  endfunction

  function automatic logic [6:0] wave_value(input logic [1:0] code);
    logic [6:0] r;
    if (code == WAVE_SAW) begin
      r = 7'd2;
    end else if (code == WAVE_TRI) begin
      r = 7'd1;
    end else begin
      r = 7'd12;
    end
    return r;
  endfunction

  function automatic logic [6:0] shape_route(input logic [1:0] w, input logic [6:0] pulse,
                                             input logic [6:0] saw, input logic [6:0] tri_cc);
    logic [6:0] r;
    if (w == WAVE_PULSE) begin
      r = pulse;
    end else if (w == WAVE_SAW) begin
      r = saw;
    end else begin
      r = tri_cc;
    end
    return r;
  endfunction

  // v * 37 / 127: estimate by shift, then one correction step
  function automatic logic [6:0] scale37(input logic [6:0] v);
    logic [12:0] p;
    logic [5:0]  q;
    logic [13:0] r;
    logic [6:0]  res;
    p = 13'(v) * 13'd37;
    q = p[12:7];
    r = 14'(p) - 14'({q, 7'b0}) + 14'(q);
    if (r >= 14'd127) begin
      res = 7'(q) + 7'd1;
    end else begin
      res = 7'(q);
    end
    return res;
  endfunction

endpackage

`default_nettype wire

/* rtl/core/midi_cc_remapper_core.sv */
// midi_cc_remapper_core: cc remapper top level, front classifier, descriptor queue, beat sequencer
// a result goes through the queue and output register, then one beat per cycle unless stalled
// a run is 1, 5 or 20 beats, none for the lfo target; one output beat per cycle at most
// inputs are taken every cycle while the two-entry descriptor queue has room
// synchronous active-low reset clears wave and lfo mode state, queue and output register
// depends on mccr_pkg, mccr_front, mccr_queue, mccr_back
`default_nettype none

module midi_cc_remapper_core #(
  parameter int SYNTH_CHANNELS = mccr_pkg::SYNTH_CHANNELS
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_ready,
  input  wire logic [3:0] in_channel,
  input  wire logic [6:0] in_controller,
  input  wire logic [6:0] in_value,
  output logic            out_valid,
  input  wire logic       out_ready,
  output logic [3:0]      out_channel,
  output logic [6:0]      out_controller,
  output logic [6:0]      out_value,
  output logic            out_last
);

  mccr_pkg::desc_t front_desc, head;
  logic            has_result, accept, q_full, head_valid, pop;

  assign in_ready = !q_full;
  assign accept   = in_valid && in_ready;

  mccr_front #(
    .SYNTH_CHANNELS(SYNTH_CHANNELS)
  ) u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_channel   (in_channel),
    .in_controller(in_controller),
    .in_value     (in_value),
    .accept       (accept),
    .desc         (front_desc),
    .has_result   (has_result)
  );

  mccr_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (accept && has_result),
    .push_data (front_desc),
    .pop       (pop),
    .full      (q_full),
    .head_valid(head_valid),
    .head      (head)
  );

  mccr_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .head_valid    (head_valid),
    .head          (head),
    .pop           (pop),
    .out_valid     (out_valid),
    .out_ready     (out_ready),
    .out_channel   (out_channel),
    .out_controller(out_controller),
    .out_value     (out_value),
    .out_last      (out_last)
  );

endmodule

`default_nettype wire

/* rtl/core/mccr_front.sv */
// mccr_front: classifies one input message into a run descriptor and keeps per-channel
// wave and lfo mode state; depends on mccr_pkg
`default_nettype none

module mccr_front #(
  parameter int SYNTH_CHANNELS = mccr_pkg::SYNTH_CHANNELS
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic [3:0]     in_channel,
  input  wire logic [6:0]     in_controller,
  input  wire logic [6:0]     in_value,
  input  wire logic           accept,
  output mccr_pkg::desc_t     desc,
  output logic                has_result
);

  localparam int IDX_W = (SYNTH_CHANNELS > 1) ? $clog2(SYNTH_CHANNELS) : 1;

  logic [1:0] lfo_mode_r     [SYNTH_CHANNELS];
  logic [1:0] osc_one_wave_r [SYNTH_CHANNELS];
  logic [1:0] osc_two_wave_r [SYNTH_CHANNELS];

  logic             is_synth;
  logic [IDX_W-1:0] idx;
  logic [1:0]       mode;
  logic [1:0]       lvl;
  logic             lfo_we, osc1_we, osc2_we;

  assign is_synth = {1'b0, in_channel} < 5'(SYNTH_CHANNELS);
  assign idx      = in_channel[IDX_W-1:0];
  assign mode     = lfo_mode_r[idx];
  assign lvl      = mccr_pkg::level3(in_value);

  always_comb begin
    desc         = '0;
    desc.channel = in_channel;
    desc.cc      = in_controller;
    desc.nval[0] = in_value;
    has_result   = 1'b1;
    lfo_we       = 1'b0;
    osc1_we      = 1'b0;
    osc2_we      = 1'b0;
    if (is_synth) begin
      unique case (in_controller) inside
        7'd33: desc.cc = 7'd56;
        7'd39: desc.cc = 7'd51;
        7'd40: desc.cc = 7'd52;
        7'd34: desc.cc = 7'd26;
        mccr_pkg::IN_OSC1_SHAPE:
          desc.cc = mccr_pkg::shape_route(osc_one_wave_r[idx], 7'd21, 7'd24, 7'd20);
        mccr_pkg::IN_OSC1_WAVE: begin
          desc.cc      = 7'd19;
          desc.nval[0] = mccr_pkg::wave_value(lvl);
          osc1_we      = 1'b1;
        end
        7'd35: desc.cc = 7'd37;
        mccr_pkg::IN_OSC2_SHAPE:
          desc.cc = mccr_pkg::shape_route(osc_two_wave_r[idx], 7'd31, 7'd35, 7'd30);
        mccr_pkg::IN_OSC2_WAVE: begin
          desc.cc      = 7'd29;
          desc.nval[0] = mccr_pkg::wave_value(lvl);
          osc2_we      = 1'b1;
        end
        7'd41: desc.cc = 7'd33;
        mccr_pkg::IN_SW_A: begin
          desc.cc      = 7'd33;
          desc.nval[0] = (in_value > 7'd63) ? 7'd127 : 7'd0;
        end
        mccr_pkg::IN_SW_B: begin
          desc.cc      = 7'd54;
          desc.nval[0] = (in_value > 7'd63) ? 7'd127 : 7'd0;
        end
        7'd43: desc.cc = 7'd74;
        7'd44: desc.cc = 7'd71;
        7'd45: desc.cc = 7'd79;
        mccr_pkg::IN_SW_INV: begin
          desc.cc      = 7'd68;
          desc.nval[0] = (in_value > 7'd63) ? 7'd0 : 7'd1;
        end
        7'd16: desc.cc = 7'd73;
        7'd17: desc.cc = 7'd75;
        7'd18: desc.cc = 7'd70;
        7'd19: desc.cc = 7'd72;
        mccr_pkg::IN_NRPN_1, mccr_pkg::IN_NRPN_2, mccr_pkg::IN_NRPN_3,
        mccr_pkg::IN_NRPN_4: begin
          desc.nrpn   = 1'b1;
          desc.lsb[0] = in_controller - 7'd19;
        end
        mccr_pkg::IN_LFO_TARGET: begin
          has_result = 1'b0;
          lfo_we     = 1'b1;
        end
        mccr_pkg::IN_LFO_RATE: begin
          desc.nrpn   = 1'b1;
          desc.lsb[0] = (mode == mccr_pkg::LFO_SHAPE) ? 7'd85 : 7'd76;
        end
        mccr_pkg::IN_LFO_SCALED: begin
          desc.nrpn    = 1'b1;
          desc.lsb[0]  = (mode == mccr_pkg::LFO_SHAPE) ? 7'd79 : 7'd70;
          desc.nval[0] = mccr_pkg::scale37(in_value);
        end
        mccr_pkg::IN_LFO_DEPTH: begin
          desc.nrpn    = 1'b1;
          desc.four    = 1'b1;
          desc.msb     = 1'b1;
          desc.nval[3] = in_value;
          if (mode == mccr_pkg::LFO_PITCH) begin
            desc.lsb     = {7'd86, 7'd87, 7'd85, 7'd84};
            desc.nval[0] = 7'd7;
            desc.nval[1] = 7'd0;
            desc.nval[2] = 7'd0;
          end else if (mode == mccr_pkg::LFO_SHAPE) begin
            desc.lsb     = {7'd91, 7'd92, 7'd90, 7'd89};
            desc.nval[0] = 7'd9;
            desc.nval[1] = 7'd0;
            desc.nval[2] = 7'd5;
          end else begin
            desc.lsb     = {7'd96, 7'd97, 7'd95, 7'd94};
            desc.nval[0] = 7'd7;
            desc.nval[1] = 7'd0;
            desc.nval[2] = 7'd12;
          end
        end
        default: desc.cc = in_controller;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < SYNTH_CHANNELS; i++) begin
        lfo_mode_r[i]     <= mccr_pkg::LFO_PITCH;
        osc_one_wave_r[i] <= mccr_pkg::WAVE_SAW;
        osc_two_wave_r[i] <= mccr_pkg::WAVE_SAW;
      end
    end else if (accept && is_synth) begin
      if (lfo_we) begin
        lfo_mode_r[idx] <= lvl;
      end
      if (osc1_we) begin
        osc_one_wave_r[idx] <= lvl;
      end
      if (osc2_we) begin
        osc_two_wave_r[idx] <= lvl;
      end
    end
  end

endmodule

`default_nettype wire

/* rtl/core/mccr_queue.sv */
// mccr_queue: short descriptor queue between the classifier and the sequencer
// depends on mccr_pkg
`default_nettype none

module mccr_queue (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            push,
  input  mccr_pkg::desc_t      push_data,
  input  wire logic            pop,
  output logic                 full,
  output logic                 head_valid,
  output mccr_pkg::desc_t      head
);

  localparam int PTR_W = (mccr_pkg::QUEUE_DEPTH > 1) ? $clog2(mccr_pkg::QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(mccr_pkg::QUEUE_DEPTH + 1);

  mccr_pkg::desc_t  mem_r [mccr_pkg::QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] count_r;
  logic             do_push, do_pop;

  assign full       = count_r == CNT_W'(mccr_pkg::QUEUE_DEPTH);
  assign head_valid = count_r != '0;
  assign head       = mem_r[rd_ptr_r];
  assign do_push    = push && !full;
  assign do_pop     = pop && head_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(mccr_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(mccr_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + 1'b1;
      end else if (do_pop && !do_push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

/* rtl/core/mccr_back.sv */
// mccr_back: expands one run descriptor into output beats, one per cycle while out_ready allows, into the
// output register; depends on mccr_pkg
`default_nettype none

module mccr_back (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        head_valid,
  input  mccr_pkg::desc_t  head,
  output logic             pop,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [3:0]       out_channel,
  output logic [6:0]       out_controller,
  output logic [6:0]       out_value,
  output logic             out_last
);

  typedef enum logic [2:0] {
    STEP_MSB,
    STEP_LSB,
    STEP_DATA,
    STEP_CLR_M,
    STEP_CLR_L
  } step_t;

  step_t      step_r;
  logic [1:0] seq_r;
  logic       out_valid_r, out_last_r;
  logic [3:0] out_channel_r;
  logic [6:0] out_controller_r, out_value_r;

  logic       load;
  logic [6:0] msg_cc, msg_val;
  logic       msg_last;

  assign load = !out_valid_r || out_ready;
  assign pop  = load && head_valid && msg_last;

  always_comb begin
    msg_cc   = head.cc;
    msg_val  = head.nval[0];
    msg_last = 1'b1;
    if (head.nrpn) begin
      msg_last = (step_r == STEP_CLR_L) && (seq_r == (head.four ? 2'd3 : 2'd0));
      unique case (step_r)
        STEP_MSB: begin
          msg_cc  = mccr_pkg::CC_NRPN_MSB;
          msg_val = {6'b0, head.msb};
        end
        STEP_LSB: begin
          msg_cc  = mccr_pkg::CC_NRPN_LSB;
          msg_val = head.lsb[seq_r];
        end
        STEP_DATA: begin
          msg_cc  = mccr_pkg::CC_DATA_ENTRY;
          msg_val = head.nval[seq_r];
        end
        STEP_CLR_M: begin
          msg_cc  = mccr_pkg::CC_RPN_MSB;
          msg_val = mccr_pkg::CC_NULL_VALUE;
        end
        default: begin
          msg_cc  = mccr_pkg::CC_RPN_LSB;
          msg_val = mccr_pkg::CC_NULL_VALUE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      step_r      <= STEP_MSB;
      seq_r       <= '0;
    end else if (load) begin
      out_valid_r <= head_valid;
      if (head_valid) begin
        out_channel_r    <= head.channel;
        out_controller_r <= msg_cc;
        out_value_r      <= msg_val;
        out_last_r       <= msg_last;
        if (msg_last) begin
          step_r <= STEP_MSB;
          seq_r  <= '0;
        end else if (step_r == STEP_CLR_L) begin
          step_r <= STEP_MSB;
          seq_r  <= seq_r + 2'd1;
        end else begin
          step_r <= step_t'(step_r + 3'd1);
        end
      end
    end
  end

  assign out_valid      = out_valid_r;
  assign out_channel    = out_channel_r;
  assign out_controller = out_controller_r;
  assign out_value      = out_value_r;
  assign out_last       = out_last_r;

endmodule

`default_nettype wire

/* rtl/core/mccr_checker.sv */
// mccr_checker: port-level assertions for midi_cc_remapper_core, bound to the top level
// depends on midi_cc_remapper_core ports and mccr_pkg controller codes
`default_nettype none

module mccr_checker (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       in_valid,
  input wire logic       in_ready,
  input wire logic [3:0] in_channel,
  input wire logic [6:0] in_controller,
  input wire logic [6:0] in_value,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic [3:0] out_channel,
  input wire logic [6:0] out_controller,
  input wire logic [6:0] out_value,
  input wire logic       out_last
);

  logic out_beat;
  assign out_beat = out_valid && out_ready;

  // output register empty after reset
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("out_valid high after reset");

  // stalled beat holds
  a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_channel)
      && $stable(out_controller) && $stable(out_value) && $stable(out_last))
    else $error("stalled output beat changed");

  // after an nrpn select msb beat the run continues on the next cycle with the lsb beat on the same channel
  a_nrpn_cont: assert property (@(posedge clk) disable iff (!rst_n)
    out_beat && !out_last && out_controller == mccr_pkg::CC_NRPN_MSB
      |=> out_valid && out_channel == $past(out_channel)
        && out_controller == mccr_pkg::CC_NRPN_LSB)
    else $error("nrpn select not followed by lsb beat");

  // null rpn msb is always followed by null rpn lsb
  a_null_pair: assert property (@(posedge clk) disable iff (!rst_n)
    out_beat && !out_last && out_controller == mccr_pkg::CC_RPN_MSB
      |=> out_valid && out_controller == mccr_pkg::CC_RPN_LSB
        && out_value == mccr_pkg::CC_NULL_VALUE)
    else $error("rpn null msb not followed by lsb beat");

endmodule

bind midi_cc_remapper_core mccr_checker u_mccr_checker (.*);

`default_nettype wire
